// ----- sv/nearest_landmark_association_macros.svh -----
// ----------------------------------------------------------------------------
// Nearest landmark association: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_LANDMARK_ASSOCIATION_MACROS_SVH
`define NEAREST_LANDMARK_ASSOCIATION_MACROS_SVH

`ifndef SYNTHESIS

// Property that holds at every edge out of reset
`define NLA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("nla assertion failed");

// Antecedent implies consequent in the next cycle
`define NLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nla assertion failed");

`else

`define NLA_ASSERT(lbl, clk, rst_n, prop)
`define NLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/nla_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest landmark association package
// Sizes, register indexes, word kinds and the scan tag type.
// ----------------------------------------------------------------------------
package nla_pkg;

    localparam int MAX_LANDMARKS = 64;
    localparam int COORD_BITS    = 24;

    localparam int IDX_W   = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int CNT_W   = $clog2(MAX_LANDMARKS + 1);
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int LIMIT_W = 49;
    localparam int DIST_W  = 2 * COORD_BITS + 1;
    localparam int BEST_W  = (DIST_W > LIMIT_W) ? DIST_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] RESET_LIMIT = 49'd10485760000000;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Travels alongside each table read through the distance pipeline
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

// ----- sv/nearest_landmark_association.sv -----
// ----------------------------------------------------------------------------
// Nearest landmark association
// Landmark table with a sequential nearest-neighbour scan per query word.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   in      | to block  | i_valid / o_stall  | kind, slot, landmark x/y, obs x/y
//   out     | from block| o_valid / i_stall  | nearest index, distance, found
//   cfg     | to block  | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A load word writes the table directly.
// A query scans n = min(landmark_count, 64) entries: one table read per
// cycle through the single read port, then the read register, the distance
// pipeline and the hand-over to the output register.
// A query with nothing to search goes straight to the hand-over.
// Reset is synchronous, active low; the table itself is not cleared.
// The output register frees the scan: a new word may enter while a result waits,
// but a finished query holds until the output register is free.
// ----------------------------------------------------------------------------
module nearest_landmark_association (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_kind,
    input  logic [nla_pkg::SLOT_W-1:0]           i_landmark_slot,
    input  logic signed [nla_pkg::COORD_BITS-1:0] i_landmark_x,
    input  logic signed [nla_pkg::COORD_BITS-1:0] i_landmark_y,
    input  logic signed [nla_pkg::COORD_BITS-1:0] i_obs_x,
    input  logic signed [nla_pkg::COORD_BITS-1:0] i_obs_y,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [nla_pkg::SLOT_W-1:0]           o_nearest_index,
    output logic [nla_pkg::LIMIT_W-1:0]          o_nearest_distance_sq,
    output logic                                 o_found,
    input  logic                                 i_cfg_we,
    input  logic [nla_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [nla_pkg::LIMIT_W-1:0]          i_cfg_data
);
    import nla_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} t_state;

    t_state r_state;

    logic [COUNT_W-1:0] r_count;
    logic [LIMIT_W-1:0] r_limit;

    logic [2*COORD_BITS-1:0] r_mem [MAX_LANDMARKS];
    logic [2*COORD_BITS-1:0] r_rd_data;
    t_tag                    r_rd_tag;

    logic signed [COORD_BITS-1:0] r_obs_x;
    logic signed [COORD_BITS-1:0] r_obs_y;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  r_n;
    logic [BEST_W-1:0] r_best;
    logic [IDX_W-1:0]  r_best_idx;
    logic              r_hit;

    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_idx;
    logic [LIMIT_W-1:0] r_out_dist;
    logic               r_out_found;

    logic              w_in_acc;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    logic              w_rd_en;
    logic              w_rd_last;
    logic [CNT_W-1:0]  w_n;
    t_tag              w_tag_out;
    logic [DIST_W-1:0] w_dist;
    logic              w_better;

    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid && !o_stall;

    // Clamp the searched count to the table depth
    assign w_n = (32'(r_count) > MAX_LANDMARKS) ? CNT_W'(MAX_LANDMARKS) : CNT_W'(r_count);

    assign w_wr_en   = w_in_acc && (i_kind == KIND_LOAD)
                     && (32'(i_landmark_slot) < MAX_LANDMARKS);
    assign w_wr_addr = IDX_W'(i_landmark_slot);
    assign w_rd_en   = (r_state == S_SCAN);
    assign w_rd_last = (CNT_W'(CNT_W'(r_rd_idx) + CNT_W'(1)) == r_n);

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_limit <= RESET_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg_data;
                default:   r_count <= r_count;
            endcase
        end
    end

    // ---------------------------------------------------------------- table
    // Loads only enter while idle, so a write never meets a scan read.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= {i_landmark_x, i_landmark_y};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag.valid <= w_rd_en;
            r_rd_tag.last  <= w_rd_last;
            r_rd_tag.idx   <= r_rd_idx;
        end
    end

    nla_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_lm_x  (r_rd_data[2*COORD_BITS-1:COORD_BITS]),
        .i_lm_y  (r_rd_data[COORD_BITS-1:0]),
        .i_obs_x (r_obs_x),
        .i_obs_y (r_obs_y),
        .o_tag   (w_tag_out),
        .o_dist  (w_dist)
    );

    // Strictly smaller only: ties keep the lower index
    assign w_better = w_tag_out.valid && (BEST_W'(w_dist) < r_best);

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_rd_idx    <= '0;
            r_n         <= '0;
        end else begin
            // S_DONE reloads the output register itself when it is taken
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (w_better) begin
                r_best     <= BEST_W'(w_dist);
                r_best_idx <= w_tag_out.idx;
                r_hit      <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_kind == KIND_QUERY)) begin
                        r_obs_x    <= i_obs_x;
                        r_obs_y    <= i_obs_y;
                        r_best     <= BEST_W'(r_limit);
                        r_best_idx <= '0;
                        r_hit      <= 1'b0;
                        r_rd_idx   <= '0;
                        r_n        <= w_n;
                        r_state    <= (w_n == '0) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                    if (w_rd_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_tag_out.valid && w_tag_out.last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold the result until the output register is free
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_hit;
                        r_out_idx   <= r_hit ? SLOT_W'(r_best_idx) : '0;
                        r_out_dist  <= r_hit ? LIMIT_W'(r_best) : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid               = r_out_valid;
    assign o_nearest_index       = r_out_idx;
    assign o_nearest_distance_sq = r_out_dist;
    assign o_found               = r_out_found;

    // ---------------------------------------------------------------- checks
    `include "nearest_landmark_association_macros.svh"

    `NLA_ASSERT(a_found_below_limit, i_clk, i_rst_n, !(r_out_valid && r_out_found) || (r_out_dist < r_limit))
    `NLA_ASSERT(a_miss_is_zero, i_clk, i_rst_n, !(r_out_valid && !r_out_found) || ((r_out_dist == '0) && (r_out_idx == '0)))
    `NLA_ASSERT(a_read_in_range, i_clk, i_rst_n, !w_rd_en || (CNT_W'(r_rd_idx) < r_n))
    `NLA_ASSERT(a_no_tag_when_idle, i_clk, i_rst_n, !(w_tag_out.valid && (r_state == S_IDLE)))
    `NLA_ASSERT_NEXT(a_done_leaves, i_clk, i_rst_n, (r_state == S_DONE) && !r_out_valid, (r_state == S_IDLE) && r_out_valid)

endmodule

// ----- sv/nla_dist.sv -----
// ----------------------------------------------------------------------------
// Nearest landmark association: distance pipeline
// Three stages: absolute difference, square, sum of squares.
// ----------------------------------------------------------------------------
module nla_dist (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  nla_pkg::t_tag                        i_tag,
    input  logic signed [nla_pkg::COORD_BITS-1:0] i_lm_x,
    input  logic signed [nla_pkg::COORD_BITS-1:0] i_lm_y,
    input  logic signed [nla_pkg::COORD_BITS-1:0] i_obs_x,
    input  logic signed [nla_pkg::COORD_BITS-1:0] i_obs_y,
    output nla_pkg::t_tag                        o_tag,
    output logic [nla_pkg::DIST_W-1:0]           o_dist
);
    import nla_pkg::*;

    logic signed [COORD_BITS:0] w_dx;
    logic signed [COORD_BITS:0] w_dy;
    logic [COORD_BITS:0]        w_ax;
    logic [COORD_BITS:0]        w_ay;

    logic [COORD_BITS-1:0]   r_mag_x;
    logic [COORD_BITS-1:0]   r_mag_y;
    logic [2*COORD_BITS-1:0] r_sq_x;
    logic [2*COORD_BITS-1:0] r_sq_y;
    logic [DIST_W-1:0]       r_dist;
    t_tag                    r_tag1;
    t_tag                    r_tag2;
    t_tag                    r_tag3;

    assign w_dx = {i_lm_x[COORD_BITS-1], i_lm_x} - {i_obs_x[COORD_BITS-1], i_obs_x};
    assign w_dy = {i_lm_y[COORD_BITS-1], i_lm_y} - {i_obs_y[COORD_BITS-1], i_obs_y};
    assign w_ax = w_dx[COORD_BITS] ? (~w_dx + 1'b1) : w_dx;
    assign w_ay = w_dy[COORD_BITS] ? (~w_dy + 1'b1) : w_dy;

    // Magnitude of a difference never exceeds 2^COORD_BITS - 1
    always_ff @(posedge i_clk) begin
        r_mag_x <= w_ax[COORD_BITS-1:0];
        r_mag_y <= w_ay[COORD_BITS-1:0];
        r_sq_x  <= r_mag_x * r_mag_x;
        r_sq_y  <= r_mag_y * r_mag_y;
        r_dist  <= {1'b0, r_sq_x} + {1'b0, r_sq_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    assign o_tag  = r_tag3;
    assign o_dist = r_dist;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest landmark association testbench
// Loads landmark tables and sends observation queries through the valid/stall
// channel. Each accepted query is scored against a local nearest-neighbour
// search over the same table and settings. A short directed set covers the
// coordinate extremes, ties, the distance limit and an empty search. Random
// phases with changing count and limit, random idling on both sides, a long
// output hold-off and a full drain then follow.
// ----------------------------------------------------------------------------
module testbench;
    import nla_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 80;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 80;
    localparam int HOLD_CYCLES     = 400;

    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};

    typedef struct {
        logic                          drain;
        logic                          kind;
        logic [SLOT_W-1:0]             slot;
        logic signed [COORD_BITS-1:0]  lx;
        logic signed [COORD_BITS-1:0]  ly;
        logic signed [COORD_BITS-1:0]  ox;
        logic signed [COORD_BITS-1:0]  oy;
    } t_landmark_word;

    typedef struct packed {
        logic [SLOT_W-1:0]  nearest_index;
        logic [LIMIT_W-1:0] distance_sq;
        logic               found;
    } t_match;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic                          i_kind = KIND_LOAD;
    logic [SLOT_W-1:0]             i_landmark_slot = '0;
    logic signed [COORD_BITS-1:0]  i_landmark_x = '0;
    logic signed [COORD_BITS-1:0]  i_landmark_y = '0;
    logic signed [COORD_BITS-1:0]  i_obs_x = '0;
    logic signed [COORD_BITS-1:0]  i_obs_y = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [SLOT_W-1:0]             o_nearest_index;
    logic [LIMIT_W-1:0]            o_nearest_distance_sq;
    logic                          o_found;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = CFG_COUNT;
    logic [LIMIT_W-1:0]            i_cfg_data = '0;

    // Local copy of the block state
    logic signed [COORD_BITS-1:0]  map_x [MAX_LANDMARKS];
    logic signed [COORD_BITS-1:0]  map_y [MAX_LANDMARKS];
    logic [COUNT_W-1:0]            search_count = '0;
    logic [LIMIT_W-1:0]            search_limit = RESET_LIMIT;

    // Positions as planned by the stimulus, used to aim queries near landmarks
    logic signed [COORD_BITS-1:0]  plan_x [MAX_LANDMARKS];
    logic signed [COORD_BITS-1:0]  plan_y [MAX_LANDMARKS];

    t_landmark_word words_to_send[$];
    t_match         awaited_matches[$];
    t_landmark_word cur_word;
    t_match         oldest_match;

    int  words_queued = 0;
    int  words_taken = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;

    nearest_landmark_association uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_kind                (i_kind),
        .i_landmark_slot       (i_landmark_slot),
        .i_landmark_x          (i_landmark_x),
        .i_landmark_y          (i_landmark_y),
        .i_obs_x               (i_obs_x),
        .i_obs_y               (i_obs_y),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_nearest_index       (o_nearest_index),
        .o_nearest_distance_sq (o_nearest_distance_sq),
        .o_found               (o_found),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_match find_nearest(input logic signed [COORD_BITS-1:0] ox,
                                            input logic signed [COORD_BITS-1:0] oy);
        t_match             best;
        logic [LIMIT_W-1:0] best_dist;
        logic [DIST_W-1:0]  d_sq;
        longint             dx;
        longint             dy;
        int                 n;
        best = '{nearest_index: '0, distance_sq: '0, found: 1'b0};
        best_dist = search_limit;
        n = (search_count > MAX_LANDMARKS) ? MAX_LANDMARKS : int'(search_count);
        for (int j = 0; j < n; j++) begin
            dx = longint'(map_x[j]) - longint'(ox);
            dy = longint'(map_y[j]) - longint'(oy);
            d_sq = DIST_W'(dx * dx + dy * dy);
            // strictly smaller only: ties stay with the lower index
            if (d_sq < best_dist) begin
                best_dist = d_sq;
                best = '{nearest_index: SLOT_W'(j), distance_sq: d_sq, found: 1'b1};
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic queue_load(input logic [SLOT_W-1:0] slot,
                              input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y);
        words_to_send.push_back('{drain: 1'b0, kind: KIND_LOAD, slot: slot, lx: x, ly: y,
                                  ox: COORD_BITS'($urandom()), oy: COORD_BITS'($urandom())});
        plan_x[slot] = x;
        plan_y[slot] = y;
        words_queued++;
    endtask

    task automatic queue_query(input logic signed [COORD_BITS-1:0] x,
                               input logic signed [COORD_BITS-1:0] y);
        words_to_send.push_back('{drain: 1'b0, kind: KIND_QUERY,
                                  slot: SLOT_W'($urandom()),
                                  lx: COORD_BITS'($urandom()), ly: COORD_BITS'($urandom()),
                                  ox: x, oy: y});
        words_queued++;
    endtask

    task automatic queue_random_word();
        int k;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        k = $urandom_range(0, MAX_LANDMARKS - 1);
        if ($urandom_range(0, 99) < 35) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    x = COORD_BITS'($urandom());
                    y = COORD_BITS'($urandom());
                end
                2: begin
                    // copy another entry so that ties turn up
                    x = plan_x[k];
                    y = plan_y[k];
                end
                default: begin
                    x = COORD_BITS'(int'($urandom_range(0, 8192)) - 4096);
                    y = COORD_BITS'(int'($urandom_range(0, 8192)) - 4096);
                end
            endcase
            queue_load(SLOT_W'($urandom_range(0, MAX_LANDMARKS - 1)), x, y);
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    if ($urandom_range(0, 3) == 0) begin
                        x = plan_x[k];
                        y = plan_y[k];
                    end else begin
                        x = plan_x[k] + COORD_BITS'(int'($urandom_range(0, 4096)) - 2048);
                        y = plan_y[k] + COORD_BITS'(int'($urandom_range(0, 4096)) - 2048);
                    end
                end
                5, 6, 7: begin
                    x = COORD_BITS'($urandom());
                    y = COORD_BITS'($urandom());
                end
                default: begin
                    x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                    y = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                end
            endcase
            queue_query(x, y);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_COUNT) begin
            search_count = value[COUNT_W-1:0];
        end else begin
            search_limit = value;
        end
    endtask

    // Wait until every queued word is taken and every match has come back
    task automatic settle();
        while (words_taken != words_queued || awaited_matches.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                words_taken++;
                if (cur_word.kind == KIND_LOAD) begin
                    map_x[cur_word.slot] = cur_word.lx;
                    map_y[cur_word.slot] = cur_word.ly;
                end else begin
                    awaited_matches.push_back(find_nearest(cur_word.ox, cur_word.oy));
                end
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (words_to_send.size() != 0 && words_to_send[0].drain) begin
                    // hold off until the block has handed back every match
                    i_valid <= 1'b0;
                    if (awaited_matches.size() == 0)
                        void'(words_to_send.pop_front());
                end else if (words_to_send.size() != 0) begin
                    if (idle_on && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(1, 17) - 1;
                        i_valid <= 1'b0;
                    end else begin
                        cur_word = words_to_send.pop_front();
                        i_valid         <= 1'b1;
                        i_kind          <= cur_word.kind;
                        i_landmark_slot <= cur_word.slot;
                        i_landmark_x    <= cur_word.lx;
                        i_landmark_y    <= cur_word.ly;
                        i_obs_x         <= cur_word.ox;
                        i_obs_y         <= cur_word.oy;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_matches.size() == 0) begin
                    report_mismatch("result with no query waiting, index", o_nearest_index, 0);
                end else begin
                    oldest_match = awaited_matches.pop_front();
                    if (o_nearest_index !== oldest_match.nearest_index)
                        report_mismatch("nearest_index", o_nearest_index,
                                        oldest_match.nearest_index);
                    if (o_nearest_distance_sq !== oldest_match.distance_sq)
                        report_mismatch("nearest_distance_sq", o_nearest_distance_sq,
                                        oldest_match.distance_sq);
                    if (o_found !== oldest_match.found)
                        report_mismatch("found", o_found, oldest_match.found);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [LIMIT_W-1:0] limit_value;
        logic [LIMIT_W-1:0] count_value;
        int                 order [MAX_LANDMARKS];
        int                 j;
        int                 tmp;

        for (int i = 0; i < MAX_LANDMARKS; i++) begin
            map_x[i]  = '0;
            map_y[i]  = '0;
            plan_x[i] = '0;
            plan_y[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty search at reset settings, then a small table with extremes and a tie
        queue_query(COORD_MIN, COORD_MAX);
        queue_load(6'd0, COORD_MIN, COORD_MIN);
        queue_load(6'd1, COORD_MAX, COORD_MAX);
        queue_load(6'd2, '0, '0);
        queue_load(6'd3, '0, '0);
        queue_load(6'd63, 24'sd100, -24'sd100);
        settle();

        write_register(CFG_COUNT, LIMIT_W'(4));
        write_register(CFG_LIMIT, LIMIT_MAX);
        queue_query(COORD_MAX, COORD_MAX);
        queue_query(COORD_MIN, COORD_MIN);
        queue_query('0, '0);
        queue_query(COORD_MAX, COORD_MIN);
        settle();

        // Largest possible distance, still under the widest limit
        write_register(CFG_COUNT, LIMIT_W'(1));
        queue_query(COORD_MAX, COORD_MAX);
        settle();

        // Zero limit never matches; a limit of one passes exact hits only
        write_register(CFG_COUNT, LIMIT_W'(4));
        write_register(CFG_LIMIT, '0);
        queue_query('0, '0);
        settle();
        write_register(CFG_LIMIT, LIMIT_W'(1));
        queue_query('0, '0);
        queue_query(24'sd1, '0);
        settle();

        // Fill every slot in shuffled order before any wide search
        for (int i = 0; i < MAX_LANDMARKS; i++)
            order[i] = i;
        for (int i = MAX_LANDMARKS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < MAX_LANDMARKS; i++)
            queue_load(SLOT_W'(order[i]), COORD_BITS'($urandom()), COORD_BITS'($urandom()));
        settle();
        write_register(CFG_COUNT, LIMIT_W'(MAX_LANDMARKS));
        write_register(CFG_LIMIT, RESET_LIMIT);
        for (int i = 0; i < 16; i++)
            queue_random_word();
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_on = (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0: count_value = '0;
                1: count_value = LIMIT_W'(1);
                2: count_value = LIMIT_W'(MAX_LANDMARKS);
                3: count_value = LIMIT_W'(127);
                4: count_value = LIMIT_W'($urandom_range(1, 8));
                default: count_value = LIMIT_W'($urandom_range(1, 127));
            endcase
            case ($urandom_range(0, 5))
                0: limit_value = RESET_LIMIT;
                1: limit_value = LIMIT_MAX;
                2: limit_value = '0;
                3: limit_value = LIMIT_W'($urandom());
                default: limit_value = LIMIT_W'({$urandom(), $urandom()});
            endcase
            if (p == 0) begin
                count_value = LIMIT_W'(127);
                limit_value = LIMIT_MAX;
            end
            write_register(CFG_COUNT, count_value);
            write_register(CFG_LIMIT, limit_value);
            for (int w = 0; w < WORDS_PER_PHASE; w++) begin
                if (p == 3 && w == WORDS_PER_PHASE / 2) begin
                    words_to_send.push_back('{drain: 1'b1, kind: KIND_LOAD, slot: '0,
                                              lx: '0, ly: '0, ox: '0, oy: '0});
                end
                queue_random_word();
            end
            // long output hold-off while the sender keeps offering words
            if (p == 1)
                hold_req = 1'b1;
            settle();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/nla_pkg.sv
sv/nla_dist.sv
sv/nearest_landmark_association.sv
sim/testbench.sv
